FILE: rtl/aveb_pkg.sv
package aveb_pkg;

    localparam logic [1:0] CMD_SINT = 2'd0;
    localparam logic [1:0] CMD_UINT = 2'd1;
    localparam logic [1:0] CMD_STR_INDEX = 2'd2;
    localparam logic [1:0] CMD_RAW_HEAP = 2'd3;

    localparam logic [2:0] ENC_INT8 = 3'd0;
    localparam logic [2:0] ENC_INT16 = 3'd1;
    localparam logic [2:0] ENC_INT32 = 3'd2;
    localparam logic [2:0] ENC_INT64 = 3'd3;
    localparam logic [2:0] ENC_LEB_INDEX = 3'd4;
    localparam logic [2:0] ENC_RAW_HEAP = 3'd5;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [63:0] value;
        logic [63:0] heap_offset;
    } in_item_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [2:0] encoding;
        logic       last;
    } out_item_t;

endpackage

FILE: rtl/aveb_width.sv
module aveb_width (
    input  logic [1:0]  cmd,
    input  logic [63:0] value,
    output logic [2:0]  int_enc
);

    logic        sign_fold;
    logic [63:0] folded;
    logic [63:0] mag;

    // A signed value is folded so that negative numbers count by their
    // one's complement, then doubled so the sign bit needs room too.
    assign sign_fold = (cmd == aveb_pkg::CMD_SINT) && value[63];
    assign folded = value ^ {64{sign_fold}};
    assign mag = (cmd == aveb_pkg::CMD_SINT) ? {folded[62:0], 1'b0} : value;

    always_comb
    begin
        if (mag[63:8] == 56'd0)
        begin
            int_enc = aveb_pkg::ENC_INT8;
        end
        else if (mag[63:16] == 48'd0)
        begin
            int_enc = aveb_pkg::ENC_INT16;
        end
        else if (mag[63:32] == 32'd0)
        begin
            int_enc = aveb_pkg::ENC_INT32;
        end
        else
        begin
            int_enc = aveb_pkg::ENC_INT64;
        end
    end

endmodule

FILE: rtl/aveb_serializer.sv
module aveb_serializer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  aveb_pkg::in_item_t   in_item,
    input  logic [2:0]           int_enc,
    output logic                 in_stall,
    output logic                 out_valid,
    output aveb_pkg::out_item_t  out_item,
    input  logic                 out_stall
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INT,
        ST_LEB_SIZE,
        ST_LEB_LAST
    } state_t;

    state_t              state_reg, state_next;
    logic [63:0]         sh_reg, sh_next;
    logic [63:0]         off_reg, off_next;
    logic [2:0]          cnt_reg, cnt_next;
    logic [2:0]          enc_reg, enc_next;
    logic                out_valid_reg, out_valid_next;
    aveb_pkg::out_item_t out_reg, out_next;

    logic                accept;
    logic                emit;
    logic                leb_more;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept = in_valid && (state_reg == ST_IDLE);
    assign emit = (state_reg != ST_IDLE) && (!out_valid_reg || !out_stall);
    assign leb_more = |sh_reg[63:7];

    assign out_valid = out_valid_reg;
    assign out_item = out_reg;

    always_comb
    begin
        state_next = state_reg;
        sh_next = sh_reg;
        off_next = off_reg;
        cnt_next = cnt_reg;
        enc_next = enc_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next = out_reg;

        if (accept)
        begin
            off_next = in_item.heap_offset;
            cnt_next = 3'd0;
            unique case (in_item.cmd) inside
                aveb_pkg::CMD_SINT, aveb_pkg::CMD_UINT:
                begin
                    state_next = ST_INT;
                    enc_next = int_enc;
                    // Left-align the chosen low bytes so they leave MSB first.
                    unique case (int_enc)
                        aveb_pkg::ENC_INT8:
                        begin
                            sh_next = {in_item.value[7:0], 56'd0};
                            cnt_next = 3'd0;
                        end
                        aveb_pkg::ENC_INT16:
                        begin
                            sh_next = {in_item.value[15:0], 48'd0};
                            cnt_next = 3'd1;
                        end
                        aveb_pkg::ENC_INT32:
                        begin
                            sh_next = {in_item.value[31:0], 32'd0};
                            cnt_next = 3'd3;
                        end
                        default:
                        begin
                            sh_next = in_item.value;
                            cnt_next = 3'd7;
                        end
                    endcase
                end
                aveb_pkg::CMD_STR_INDEX:
                begin
                    state_next = ST_LEB_LAST;
                    enc_next = aveb_pkg::ENC_LEB_INDEX;
                    sh_next = in_item.value;
                end
                default:
                begin
                    state_next = ST_LEB_SIZE;
                    enc_next = aveb_pkg::ENC_RAW_HEAP;
                    sh_next = in_item.value;
                end
            endcase
        end
        else if (emit)
        begin
            out_valid_next = 1'b1;
            out_next.encoding = enc_reg;
            unique case (state_reg)
                ST_INT:
                begin
                    out_next.data_byte = sh_reg[63:56];
                    out_next.last = (cnt_reg == 3'd0);
                    sh_next = {sh_reg[55:0], 8'd0};
                    cnt_next = cnt_reg - 3'd1;
                    if (cnt_reg == 3'd0)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                ST_LEB_SIZE:
                begin
                    out_next.data_byte = {leb_more, sh_reg[6:0]};
                    out_next.last = 1'b0;
                    if (leb_more)
                    begin
                        sh_next = {7'd0, sh_reg[63:7]};
                    end
                    else
                    begin
                        // The size is done; the heap offset follows.
                        sh_next = off_reg;
                        state_next = ST_LEB_LAST;
                    end
                end
                default:
                begin
                    out_next.data_byte = {leb_more, sh_reg[6:0]};
                    out_next.last = !leb_more;
                    sh_next = {7'd0, sh_reg[63:7]};
                    if (!leb_more)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg <= sh_next;
        off_reg <= off_next;
        cnt_reg <= cnt_next;
        enc_reg <= enc_next;
        out_reg <= out_next;
    end

endmodule

FILE: rtl/attribute_value_byte_encoder.sv
// Attribute value byte encoder.
// The input channel (in_valid, in_stall, in_item) takes one typed value:
// a signed or unsigned integer, a string-table index or a raw heap block.
// The output channel (out_valid, out_stall, out_item) returns the encoded
// bytes in stream order, one item per byte, each with its encoding code and
// a last flag on the final byte of the input item.
// Integers leave as 1, 2, 4 or 8 big-endian bytes; indexes leave as LEB128;
// raw blocks leave as LEB128 size followed by LEB128 offset.
// The first byte is registered into the output register once the accepting
// edge has set up the shifter; after that the byte shifter yields one byte per
// cycle while the receiver does not stall. The input side stays stalled until
// the last byte of an item has left the shifter.
// While the receiver stalls, the output register holds its byte and the
// shifter waits. A new item can be accepted while the last byte of the
// previous one still waits in the output register.
// Reset clears the control state and empties the output register.
module attribute_value_byte_encoder (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  aveb_pkg::in_item_t   in_item,
    output logic                 out_valid,
    input  logic                 out_stall,
    output aveb_pkg::out_item_t  out_item
);

    logic [2:0] int_enc;

    aveb_width u_width (
        .cmd     (in_item.cmd),
        .value   (in_item.value),
        .int_enc (int_enc)
    );

    aveb_serializer u_serializer (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_item   (in_item),
        .int_enc   (int_enc),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_item  (out_item),
        .out_stall (out_stall)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("encoder not busy after accepting an item");

    a_last_closes_item: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_stall) |-> (out_valid && out_item.last))
        else $error("item finished without a last byte");

    a_enc_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.encoding <= aveb_pkg::ENC_RAW_HEAP))
        else $error("encoding code out of range");

endmodule
